// ----- src/lsbp_pkg.sv -----
// Shared types and constants for the LSB-first bit packer.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package lsbp_pkg;

  localparam int unsigned MAX_FIELD_BITS = 63;
  localparam int unsigned MAX_QUANT_BITS = 32;
  localparam int unsigned DIV_STEPS      = 32;
  localparam int unsigned DIV_CNT_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    FN_WRITE = 2'd0,
    FN_QUANT = 2'd1,
    FN_FLUSH = 2'd2,
    FN_CLEAR = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_WIDTH  = 3'd1,
    ERR_VALUE  = 3'd2,
    ERR_QWIDTH = 3'd3,
    ERR_RANGE  = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_PACK   = 2'd1,
    KIND_QUANT  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DECODE = 3'd1,
    ST_QPREP  = 3'd2,
    ST_QDIV   = 3'd3,
    ST_QLOAD  = 3'd4,
    ST_PACK   = 3'd5
  } state_e;

  typedef struct packed {
    logic latch;
    logic calc;
    logic emit_single;
    logic qprep;
    logic div_step;
    logic load_plain;
    logic load_quot;
    logic pack_step;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  q_direct;
    logic  div_last;
    logic  pack_last;
    logic  out_free;
  } status_t;

endpackage

`default_nettype wire

// ----- src/lsbp_if.sv -----
// Valid/ready channel interfaces for the packer's input items and result items.
// Depends on nothing; the field widths are fixed.
`default_nettype none

interface lsbp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [62:0]        data_value;
  logic [5:0]         field_width;
  logic signed [31:0] sample;
  logic signed [31:0] range_low;
  logic signed [31:0] range_high;

  modport source (
    output valid, func, data_value, field_width, sample, range_low, range_high,
    input  ready
  );
  modport sink (
    input  valid, func, data_value, field_width, sample, range_low, range_high,
    output ready
  );
endinterface

interface lsbp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last;
  logic [31:0] total_bits;
  logic [2:0]  error_code;

  modport source (
    output valid, out_byte, byte_valid, last, total_bits, error_code,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_valid, last, total_bits, error_code,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/lsbp_ctrl.sv -----
// Sequencer of the packer: accepts items and issues datapath commands.
// Depends on lsbp_pkg (state, command and status types).
`default_nettype none

module lsbp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lsbp_pkg::status_t status_i,
  output lsbp_pkg::cmd_t    cmd_o
);

  lsbp_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsbp_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lsbp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = lsbp_pkg::ST_DECODE;
        end
      end
      lsbp_pkg::ST_DECODE: begin
        unique case (status_i.kind)
          lsbp_pkg::KIND_SINGLE: begin
            if (status_i.out_free) begin
              cmd_o.emit_single = 1'b1;
              state_d           = lsbp_pkg::ST_IDLE;
            end
          end
          lsbp_pkg::KIND_PACK: begin
            cmd_o.load_plain = 1'b1;
            state_d          = lsbp_pkg::ST_PACK;
          end
          lsbp_pkg::KIND_QUANT: begin
            cmd_o.calc = 1'b1;
            state_d    = lsbp_pkg::ST_QPREP;
          end
          default: state_d = lsbp_pkg::ST_IDLE;
        endcase
      end
      lsbp_pkg::ST_QPREP: begin
        cmd_o.qprep = 1'b1;
        state_d     = status_i.q_direct ? lsbp_pkg::ST_PACK : lsbp_pkg::ST_QDIV;
      end
      lsbp_pkg::ST_QDIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = lsbp_pkg::ST_QLOAD;
        end
      end
      lsbp_pkg::ST_QLOAD: begin
        cmd_o.load_quot = 1'b1;
        state_d         = lsbp_pkg::ST_PACK;
      end
      lsbp_pkg::ST_PACK: begin
        if (status_i.out_free) begin
          cmd_o.pack_step = 1'b1;
          if (status_i.pack_last) begin
            state_d = lsbp_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lsbp_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- src/lsbp_dp.sv -----
// Datapath of the packer: item registers, checks, quantizer divider,
// byte packer, stream state and result register. Depends on lsbp_pkg.
`default_nettype none

module lsbp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lsbp_pkg::cmd_t     cmd_i,
  output lsbp_pkg::status_t  status_o,
  input  logic [1:0]         func_i,
  input  logic [62:0]        data_value_i,
  input  logic [5:0]         field_width_i,
  input  logic signed [31:0] sample_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [7:0]         out_byte_o,
  output logic               byte_valid_o,
  output logic               last_o,
  output logic [31:0]        total_bits_o,
  output logic [2:0]         error_code_o
);

  // latched item
  lsbp_pkg::func_e    func_q;
  logic [62:0]        value_q;
  logic [5:0]         width_q;
  logic signed [31:0] sample_q, low_q, high_q;

  // quantizer
  logic signed [32:0] num_q, den_q;
  logic [31:0]        rem_q, quo_q;
  logic [lsbp_pkg::DIV_CNT_W-1:0] cnt_q;

  // packer and stream state
  logic [62:0] pval_q;
  logic [5:0]  prem_q;
  logic [6:0]  pend_q;
  logic [2:0]  fill_q;
  logic [31:0] bits_q;

  // result register
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        byte_valid_q;
  logic        last_q;
  logic [31:0] total_q;
  lsbp_pkg::err_e err_q;

  lsbp_pkg::kind_e kind;
  lsbp_pkg::err_e  err_code;
  logic            out_free;

  always_comb begin
    kind     = lsbp_pkg::KIND_SINGLE;
    err_code = lsbp_pkg::ERR_NONE;
    case (func_q)
      lsbp_pkg::FN_WRITE: begin
        if (width_q == 6'd0 || width_q > 6'(lsbp_pkg::MAX_FIELD_BITS)) begin
          err_code = lsbp_pkg::ERR_WIDTH;
        end else if ((value_q >> width_q) != 63'd0) begin
          err_code = lsbp_pkg::ERR_VALUE;
        end else begin
          kind = lsbp_pkg::KIND_PACK;
        end
      end
      lsbp_pkg::FN_QUANT: begin
        if (width_q == 6'd0 || width_q > 6'(lsbp_pkg::MAX_QUANT_BITS)) begin
          err_code = lsbp_pkg::ERR_QWIDTH;
        end else if (high_q <= low_q) begin
          err_code = lsbp_pkg::ERR_RANGE;
        end else begin
          kind = lsbp_pkg::KIND_QUANT;
        end
      end
      default: kind = lsbp_pkg::KIND_SINGLE;
    endcase
  end

  // quantizer preparation: saturation, scale factor and numerator * (2^w - 1)
  logic        num_pos, num_sat, q_direct;
  logic [32:0] one_sh;
  logic [31:0] maxq;
  logic [63:0] prod;

  assign num_pos  = !num_q[32] && (num_q != 33'sd0);
  assign num_sat  = num_q >= den_q;
  assign q_direct = !num_pos || num_sat;
  assign one_sh   = 33'd1 << width_q;
  assign maxq     = 32'(one_sh - 33'd1);
  assign prod     = ({32'd0, num_q[31:0]} << width_q) - {32'd0, num_q[31:0]};

  // one restoring divide step
  logic [32:0] div_t, div_diff;
  logic        div_ge;

  assign div_t    = {rem_q, quo_q[31]};
  assign div_diff = div_t - {1'b0, den_q[31:0]};
  assign div_ge   = div_t >= {1'b0, den_q[31:0]};

  // pack load source
  logic        pack_load;
  logic [62:0] ld_val;
  logic [32:0] bits_sum;

  assign pack_load = cmd_i.load_plain | cmd_i.load_quot | (cmd_i.qprep & q_direct);
  assign bits_sum  = {1'b0, bits_q} + {27'd0, width_q};

  always_comb begin
    ld_val = value_q;
    if (cmd_i.load_quot) begin
      ld_val = {31'd0, quo_q};
    end else if (cmd_i.qprep) begin
      ld_val = num_pos ? {31'd0, maxq} : 63'd0;
    end
  end

  // one packer step: fill the partial byte from the low bits of the field
  logic [3:0]  room, take;
  logic        short;
  logic [7:0]  mask8, chunk, acc;
  logic [5:0]  rem_n;
  logic [62:0] pval_n;
  logic        tail, pack_last;

  assign room      = 4'd8 - {1'b0, fill_q};
  assign short     = prem_q < {2'd0, room};
  assign take      = short ? prem_q[3:0] : room;
  assign mask8     = 8'((9'd1 << take) - 9'd1);
  assign chunk     = pval_q[7:0] & mask8;
  assign acc       = {1'b0, pend_q} | (chunk << fill_q);
  assign rem_n     = prem_q - {2'd0, take};
  assign pval_n    = pval_q >> take;
  assign tail      = rem_n < 6'd8;
  assign pack_last = short || tail;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.kind      = kind;
    status_o.q_direct  = q_direct;
    status_o.div_last  = (cnt_q == '1);
    status_o.pack_last = pack_last;
    status_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q   <= lsbp_pkg::func_e'(func_i);
      value_q  <= data_value_i;
      width_q  <= field_width_i;
      sample_q <= sample_i;
      low_q    <= range_low_i;
      high_q   <= range_high_i;
    end
    if (cmd_i.calc) begin
      num_q <= 33'(sample_q) - 33'(low_q);
      den_q <= 33'(high_q) - 33'(low_q);
    end
    if (cmd_i.qprep) begin
      rem_q <= prod[63:32];
      quo_q <= prod[31:0];
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? div_diff[31:0] : div_t[31:0];
      quo_q <= {quo_q[30:0], div_ge};
      cnt_q <= cnt_q + {{(lsbp_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
    end
    if (pack_load) begin
      pval_q <= ld_val;
      prem_q <= width_q;
    end else if (cmd_i.pack_step) begin
      pval_q <= pval_n;
      prem_q <= short ? 6'd0 : rem_n;
    end
  end

  logic stream_clear;
  assign stream_clear = cmd_i.emit_single &&
                        (func_q == lsbp_pkg::FN_FLUSH || func_q == lsbp_pkg::FN_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      fill_q <= '0;
      bits_q <= '0;
    end else if (stream_clear) begin
      pend_q <= '0;
      fill_q <= '0;
      bits_q <= '0;
    end else if (pack_load) begin
      bits_q <= bits_sum[32] ? '1 : bits_sum[31:0];
    end else if (cmd_i.pack_step) begin
      if (short) begin
        pend_q <= acc[6:0];
        fill_q <= fill_q + prem_q[2:0];
      end else if (tail) begin
        pend_q <= pval_n[6:0];
        fill_q <= rem_n[2:0];
      end else begin
        pend_q <= '0;
        fill_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_single || cmd_i.pack_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  logic flush_byte;
  assign flush_byte = (func_q == lsbp_pkg::FN_FLUSH) && (fill_q != 3'd0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_single) begin
      out_byte_q   <= flush_byte ? {1'b0, pend_q} : 8'd0;
      byte_valid_q <= flush_byte;
      last_q       <= 1'b1;
      total_q      <= (func_q == lsbp_pkg::FN_FLUSH) ? bits_q : 32'd0;
      err_q        <= err_code;
    end else if (cmd_i.pack_step) begin
      out_byte_q   <= short ? 8'd0 : acc;
      byte_valid_q <= !short;
      last_q       <= pack_last;
      total_q      <= 32'd0;
      err_q        <= lsbp_pkg::ERR_NONE;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign byte_valid_o = byte_valid_q;
  assign last_o       = last_q;
  assign total_bits_o = total_q;
  assign error_code_o = err_q;

endmodule

`default_nettype wire

// ----- src/lsb_first_bit_packer.sv -----
// An item is accepted, then decoded; a write then gives one result per cycle while the
// output is free (up to 8). Errors, flush and clear give their single result after
// decode. Quantize adds a preparation step, plus the bit-serial restoring divider when
// the sample lies strictly inside the range; the divider sets the worst case. Results
// pass through one output register. Reset clears the partial byte and the bit count
// without emitting anything. Depends on lsbp_pkg, lsbp_if, lsbp_ctrl, lsbp_dp.
`default_nettype none

module lsb_first_bit_packer (
  input  logic       clk_i,
  input  logic       rst_ni,
  lsbp_in_if.sink    in_i,
  lsbp_out_if.source out_o
);

  lsbp_pkg::cmd_t    cmd;
  lsbp_pkg::status_t status;
  logic              in_ready;

  assign in_i.ready = in_ready;

  lsbp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lsbp_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .func_i        (in_i.func),
    .data_value_i  (in_i.data_value),
    .field_width_i (in_i.field_width),
    .sample_i      (in_i.sample),
    .range_low_i   (in_i.range_low),
    .range_high_i  (in_i.range_high),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_byte_o    (out_o.out_byte),
    .byte_valid_o  (out_o.byte_valid),
    .last_o        (out_o.last),
    .total_bits_o  (out_o.total_bits),
    .error_code_o  (out_o.error_code)
  );

  a_one_item_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_ready) |=> !in_ready)
    else $error("input accepted again right after a transfer");

  a_error_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.error_code != lsbp_pkg::ERR_NONE) |-> (out_o.last && !out_o.byte_valid))
    else $error("error result carries a byte or is not last");

  a_total_on_flush_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.total_bits != 32'd0) |->
    (out_o.last && out_o.error_code == lsbp_pkg::ERR_NONE))
    else $error("bit count shown outside a flush result");

endmodule

`default_nettype wire

// ----- tb/lsbp_stream_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the LSB-first bit packer: watches both channels, predicts the
// result transfers of every accepted item and compares them field by field.
// Depends on lsbp_pkg and the channel interfaces of lsbp_if.
module lsbp_stream_checker (
  input  logic clk_i,
  input  logic rst_ni,
  lsbp_in_if   in_mon,
  lsbp_out_if  out_mon,
  output int   fail_count_o,
  output int   awaiting_o,
  output int   checked_o,
  output int   bytes_o
);

  typedef struct packed {
    logic [7:0]     out_byte;
    logic           byte_valid;
    logic           last;
    logic [31:0]    total_bits;
    lsbp_pkg::err_e error_code;
  } packer_result_t;

  packer_result_t awaited[$];

  // predicted packer state
  logic [7:0]  part_byte;
  int          part_fill;
  logic [31:0] bit_total;

  task automatic clear_state();
    part_byte = '0;
    part_fill = 0;
    bit_total = '0;
  endtask

  task automatic push_single(input lsbp_pkg::err_e code, input logic [31:0] tot);
    packer_result_t r;
    r = '0;
    r.last = 1'b1;
    r.total_bits = tot;
    r.error_code = code;
    awaited.push_back(r);
  endtask

  // Bits go in one at a time, LSB first; a completed byte is held back so the
  // final one of the item can carry last.
  task automatic pack_field(input logic [62:0] value, input int width);
    packer_result_t held;
    logic holding;
    holding = 1'b0;
    held = '0;
    for (int i = 0; i < width; i++) begin
      part_byte[part_fill] = value[i];
      part_fill++;
      if (part_fill == 8) begin
        if (holding) begin
          awaited.push_back(held);
        end
        held = '0;
        held.out_byte = part_byte;
        held.byte_valid = 1'b1;
        held.error_code = lsbp_pkg::ERR_NONE;
        holding = 1'b1;
        part_byte = '0;
        part_fill = 0;
      end
    end
    if (32'hFFFF_FFFF - bit_total < width) begin
      bit_total = 32'hFFFF_FFFF;
    end else begin
      bit_total += width;
    end
    if (holding) begin
      held.last = 1'b1;
      awaited.push_back(held);
    end else begin
      push_single(lsbp_pkg::ERR_NONE, 32'd0);
    end
  endtask

  task automatic predict_item();
    packer_result_t r;
    int w;
    longint smp, lo, hi, num, den;
    logic [63:0] maxq, quot;
    w = int'(in_mon.field_width);
    case (lsbp_pkg::func_e'(in_mon.func))
      lsbp_pkg::FN_WRITE: begin
        if (w < 1 || w > lsbp_pkg::MAX_FIELD_BITS) begin
          push_single(lsbp_pkg::ERR_WIDTH, 32'd0);
        end else if (w < 63 && (in_mon.data_value >> w) != 63'd0) begin
          push_single(lsbp_pkg::ERR_VALUE, 32'd0);
        end else begin
          pack_field(in_mon.data_value, w);
        end
      end
      lsbp_pkg::FN_QUANT: begin
        smp = longint'(in_mon.sample);
        lo = longint'(in_mon.range_low);
        hi = longint'(in_mon.range_high);
        if (w < 1 || w > lsbp_pkg::MAX_QUANT_BITS) begin
          push_single(lsbp_pkg::ERR_QWIDTH, 32'd0);
        end else if (hi <= lo) begin
          push_single(lsbp_pkg::ERR_RANGE, 32'd0);
        end else begin
          maxq = (64'd1 << w) - 64'd1;
          num = smp - lo;
          den = hi - lo;
          if (num <= 0) begin
            quot = 64'd0;
          end else if (num >= den) begin
            quot = maxq;
          end else begin
            quot = ($unsigned(num) * maxq) / $unsigned(den);
          end
          pack_field(quot[62:0], w);
        end
      end
      lsbp_pkg::FN_FLUSH: begin
        r = '0;
        r.last = 1'b1;
        r.total_bits = bit_total;
        r.error_code = lsbp_pkg::ERR_NONE;
        if (part_fill != 0) begin
          r.out_byte = part_byte & 8'h7F;
          r.byte_valid = 1'b1;
        end
        awaited.push_back(r);
        clear_state();
      end
      default: begin
        clear_state();
        push_single(lsbp_pkg::ERR_NONE, 32'd0);
      end
    endcase
  endtask

  task automatic check_result();
    packer_result_t exp_r;
    if (awaited.size() == 0) begin
      $error("unexpected result transfer: out_byte %02h byte_valid %0b error_code %0d",
             out_mon.out_byte, out_mon.byte_valid, out_mon.error_code);
      fail_count_o++;
    end else begin
      exp_r = awaited.pop_front();
      checked_o++;
      if (exp_r.byte_valid) begin
        bytes_o++;
      end
      if (out_mon.out_byte !== exp_r.out_byte) begin
        $error("out_byte: expected %02h, actual %02h", exp_r.out_byte, out_mon.out_byte);
        fail_count_o++;
      end
      if (out_mon.byte_valid !== exp_r.byte_valid) begin
        $error("byte_valid: expected %0b, actual %0b", exp_r.byte_valid, out_mon.byte_valid);
        fail_count_o++;
      end
      if (out_mon.last !== exp_r.last) begin
        $error("last: expected %0b, actual %0b", exp_r.last, out_mon.last);
        fail_count_o++;
      end
      if (out_mon.total_bits !== exp_r.total_bits) begin
        $error("total_bits: expected %0d, actual %0d", exp_r.total_bits, out_mon.total_bits);
        fail_count_o++;
      end
      if (out_mon.error_code !== exp_r.error_code) begin
        $error("error_code: expected %0d, actual %0d", exp_r.error_code, out_mon.error_code);
        fail_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      awaited.delete();
      fail_count_o = 0;
      checked_o = 0;
      bytes_o = 0;
      awaiting_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_item();
      end
      if (out_mon.valid && out_mon.ready) begin
        check_result();
      end
      awaiting_o <= awaited.size();
    end
  end

endmodule

// ----- tb/lsb_first_bit_packer_tb.sv -----
`timescale 1ns / 100ps
// Top of the packer testbench: clock, reset, item stimulus under three idle
// patterns with one long output hold-off, and the verdict.
// Uses lsbp_pkg, lsbp_if, the packer RTL and lsbp_stream_checker.
module lsb_first_bit_packer_tb;

  localparam int ITEMS_PER_PHASE = 102;
  localparam int HOLD_OFF_ITEMS  = 30;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int STALL_LIMIT     = 4000;
  localparam int DRAIN_CYCLES    = 80;

  typedef struct {
    lsbp_pkg::func_e    func;
    logic [62:0]        value;
    logic [5:0]         width;
    logic signed [31:0] sample;
    logic signed [31:0] range_low;
    logic signed [31:0] range_high;
  } packer_item_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_off_req = 1'b0;
  int   items_sent = 0;
  int   fail_count;
  int   awaiting;
  int   checked;
  int   bytes_seen;

  lsbp_in_if  in_ch ();
  lsbp_out_if out_ch ();

  lsb_first_bit_packer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  lsbp_stream_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fail_count_o (fail_count),
    .awaiting_o   (awaiting),
    .checked_o    (checked),
    .bytes_o      (bytes_seen)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic packer_item_t make_item(input lsbp_pkg::func_e f,
                                             input logic [62:0] v,
                                             input logic [5:0] w, input int smp,
                                             input int lo, input int hi);
    packer_item_t it;
    it.func = f;
    it.value = v;
    it.width = w;
    it.sample = smp;
    it.range_low = lo;
    it.range_high = hi;
    return it;
  endfunction

  function automatic packer_item_t random_item();
    packer_item_t it;
    int roll, w, r_lo, r_hi;
    longint lo, hi, span, step;
    longint unsigned u;
    roll = $urandom_range(99);
    u = {$urandom, $urandom};
    it.value = u[62:0];
    it.width = 6'($urandom_range(63));
    it.sample = $urandom;
    it.range_low = $urandom;
    it.range_high = $urandom;
    if (roll < 52) begin
      it.func = lsbp_pkg::FN_WRITE;
      w = ($urandom_range(99) < 3) ? 0 : $urandom_range(1, 63);
      it.width = 6'(w);
      if (w > 0 && w < 63) begin
        it.value = it.value & ((63'd1 << w) - 63'd1);
        if ($urandom_range(99) < 8) begin
          it.value[$urandom_range(62, w)] = 1'b1;
        end
      end
    end else if (roll < 82) begin
      it.func = lsbp_pkg::FN_QUANT;
      w = ($urandom_range(99) < 6) ? $urandom_range(33, 63) : $urandom_range(1, 32);
      if ($urandom_range(99) < 2) begin
        w = 0;
      end
      it.width = 6'(w);
      r_lo = $urandom;
      lo = r_lo;
      case ($urandom_range(9))
        0: begin
          step = $urandom_range(0, 1000);
          hi = lo - step;
        end
        1, 2, 3: begin
          step = $urandom_range(1, 65536);
          hi = lo + step;
        end
        default: begin
          r_hi = $urandom;
          hi = r_hi;
          if (hi < lo) begin
            step = lo;
            lo = hi;
            hi = step;
          end
        end
      endcase
      if (hi > 64'sd2147483647) begin
        lo = lo - (hi - 64'sd2147483647);
        hi = 64'sd2147483647;
      end
      if (hi < -64'sd2147483648) begin
        hi = -64'sd2147483648;
      end
      span = hi - lo;
      roll = $urandom_range(9);
      if (span > 0 && roll < 7) begin
        u = {$urandom, $urandom};
        it.sample = 32'(lo + longint'(u % span));
      end else if (roll == 7) begin
        it.sample = ($urandom_range(1) != 0) ? 32'(hi) : 32'(lo);
      end
      it.range_low = 32'(lo);
      it.range_high = 32'(hi);
    end else if (roll < 94) begin
      it.func = lsbp_pkg::FN_FLUSH;
    end else begin
      it.func = lsbp_pkg::FN_CLEAR;
    end
    return it;
  endfunction

  task automatic drive_item(input packer_item_t it);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < tx_idle_pct) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.data_value <= it.value;
    in_ch.field_width <= it.width;
    in_ch.sample <= it.sample;
    in_ch.range_low <= it.range_low;
    in_ch.range_high <= it.range_high;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  // result side: random back-pressure, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("lsb_first_bit_packer_tb NOT OK");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = lsbp_pkg::FN_WRITE;
    in_ch.data_value = '0;
    in_ch.field_width = '0;
    in_ch.sample = '0;
    in_ch.range_low = '0;
    in_ch.range_high = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_idle_pct = 24;
    rx_idle_pct = 72;

    // directed: field extremes, every error, quantizer clamps and flush/clear corners
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'd1, 6'd1, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, {63{1'b1}}, 6'd63, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'h55, 6'd7, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'd0, 6'd0, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'd8, 6'd3, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'd1 << 62, 6'd62, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd0, 0, 0, 100));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd33, 0, 0, 100));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd63, 0, 100, -100));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd8, 5, 7, 7));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd8, 5, 9, 7));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd32,
                         0, 32'h8000_0000, 32'h7FFF_FFFF));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd32,
                         32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd32,
                         32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd12, 32'h8000_0000, -100, 100));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd12, 32'h7FFF_FFFF, -100, 100));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd1, 2, 0, 3));
    drive_item(make_item(lsbp_pkg::FN_QUANT, '0, 6'd16,
                         32'h0001_8000, 32'h0001_0000, 32'h0002_0000));
    drive_item(make_item(lsbp_pkg::FN_FLUSH, '0, '0, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_FLUSH, '0, '0, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'hA5, 6'd8, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_FLUSH, '0, '0, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_WRITE, 63'h1B, 6'd5, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_CLEAR, '0, '0, 0, 0, 0));
    drive_item(make_item(lsbp_pkg::FN_FLUSH, '0, '0, 0, 0, 0));

    for (int i = 0; i < ITEMS_PER_PHASE; i++) drive_item(random_item());

    tx_idle_pct = 72;
    rx_idle_pct = 24;
    for (int i = 0; i < ITEMS_PER_PHASE; i++) drive_item(random_item());

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < HOLD_OFF_ITEMS; i++) drive_item(random_item());
    for (int i = 0; i < ITEMS_PER_PHASE - HOLD_OFF_ITEMS; i++) drive_item(random_item());

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (awaiting != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items: directed corners, then random writes, quantizes, flushes",
             items_sent);
    $display("and clears under three idle patterns and a long hold-off; %0d results (%0d bytes).",
             checked, bytes_seen);
    if (fail_count == 0) begin
      $display("lsb_first_bit_packer_tb OK");
    end else begin
      $display("lsb_first_bit_packer_tb NOT OK");
    end
    $finish;
  end

endmodule
